/* rtl/qei_pkg.sv */
// qei_pkg: shared types and constants for the quadratic ease interpolator.
// Used by qei_div_pipe and quad_ease_interpolator_unit; no dependencies.
package qei_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int FRAME_BITS_DEF = 16;

  // easing is Q2.14, one is 2^14
  localparam int          EASE_SHIFT = 14;
  localparam logic [14:0] EASE_ONE   = 15'd16384;
  localparam logic signed [15:0] EASE_MAX = 16'sd16384;
  localparam logic signed [15:0] EASE_MIN = -16'sd16384;

  localparam logic signed [33:0] RES_MAX = 34'sd2147483647;
  localparam logic signed [33:0] RES_MIN = -34'sd2147483648;
  localparam logic [31:0] RES_MAX_32 = 32'h7FFF_FFFF;
  localparam logic [31:0] RES_MIN_32 = 32'h8000_0000;

  // which value the request resolves to
  typedef enum logic [1:0] {
    SEL_START = 2'd0,   // no duration or no elapsed time
    SEL_END   = 2'd1,   // elapsed at or past duration
    SEL_EASE  = 2'd2    // interpolate
  } qei_sel_t;

  typedef struct packed {
    logic [15:0] elapsed_frames;
    logic [15:0] total_frames;
    logic [31:0] start_value;
    logic [31:0] change_value;
    logic [15:0] ease_amount;
  } qei_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        saturated;
  } qei_out_t;

  // per-transaction data that rides alongside the arithmetic
  typedef struct packed {
    logic [31:0] start_value;
    logic [31:0] change_value;
    qei_sel_t    sel;
    logic        neg;    // ease-in form
    logic [14:0] coef;   // |clamped easing|
  } qei_side_t;

endpackage

/* rtl/qei_div_pipe.sv */
// qei_div_pipe: pipelined restoring divider, one quotient bit per stage.
// Forms t = (dividend << FRAC_BITS) / divisor for dividend < divisor; uses qei_pkg.
module qei_div_pipe #(
  parameter int FRAC_BITS  = qei_pkg::FRAC_BITS_DEF,
  parameter int FRAME_BITS = qei_pkg::FRAME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [FRAME_BITS-1:0]   dividend,
  input  logic [FRAME_BITS-1:0]   divisor,
  input  qei_pkg::qei_side_t      in_side,
  output logic                    out_valid,
  output logic [FRAC_BITS-1:0]    quotient,
  output qei_pkg::qei_side_t      out_side
);
  import qei_pkg::*;

  logic                  vld_r  [FRAC_BITS];
  logic [FRAME_BITS-1:0] rem_r  [FRAC_BITS];
  logic [FRAME_BITS-1:0] dvs_r  [FRAC_BITS];
  logic [FRAC_BITS-1:0]  quo_r  [FRAC_BITS];
  qei_side_t             side_r [FRAC_BITS];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
    logic                  vld_in;
    logic [FRAME_BITS-1:0] rem_in;
    logic [FRAME_BITS-1:0] dvs_in;
    logic [FRAC_BITS-1:0]  quo_in;
    qei_side_t             side_in;
    logic [FRAME_BITS:0]   rem2;
    logic [FRAME_BITS:0]   diff;
    logic                  ge;
    logic [FRAME_BITS-1:0] rem_nxt;
    logic [FRAC_BITS-1:0]  quo_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = dividend;
      assign dvs_in  = divisor;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign dvs_in  = dvs_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      rem2    = {rem_in, 1'b0};
      diff    = rem2 - {1'b0, dvs_in};
      ge      = (rem2 >= {1'b0, dvs_in});
      rem_nxt = ge ? diff[FRAME_BITS-1:0] : rem2[FRAME_BITS-1:0];
      quo_nxt = {quo_in[FRAC_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      dvs_r[i]  <= dvs_in;
      quo_r[i]  <= quo_nxt;
      side_r[i] <= side_in;
    end
  end

  assign out_valid = vld_r[FRAC_BITS-1];
  assign quotient  = quo_r[FRAC_BITS-1];
  assign out_side  = side_r[FRAC_BITS-1];

  // remainder of a real division ends below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_side.sel == SEL_EASE |-> rem_r[FRAC_BITS-1] < dvs_r[FRAC_BITS-1])
    else $error("divider remainder not below divisor");

  // interpolating transactions never carry a zero divisor
  a_dvs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_side.sel == SEL_EASE |-> dvs_r[FRAC_BITS-1] != '0)
    else $error("zero divisor reached divider output");

  // fixed latency through the divider
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> ##FRAC_BITS out_valid)
    else $error("divider dropped a transaction");

endmodule

/* rtl/quad_ease_interpolator_unit.sv */
// quad_ease_interpolator_unit: top level of the quadratic ease interpolator.
// Uses qei_pkg and instantiates qei_div_pipe.
//
//  channel   ports                     accept condition
//  -------   -----------------------   ----------------------------------
//  input     start, busy, in_data      start && !busy at a rising edge
//  result    out_valid, out_data       out_valid high for one cycle
//
// One transaction enters per cycle; busy is held low because every stage
// advances on every clock. The pipeline is FRAC_BITS divider stages
// (one quotient bit each), then the easing-factor multiply, the factor
// add/shift, the t*f multiply, the change*s multiply and the final
// add/saturate into the output register.
// rst_n is synchronous; it clears only the valid bits, so in-flight
// transactions are dropped and no result strobes during or after reset.
// The receiver cannot stall, so no stage ever holds.
module quad_ease_interpolator_unit #(
  parameter int FRAC_BITS  = qei_pkg::FRAC_BITS_DEF,
  parameter int FRAME_BITS = qei_pkg::FRAME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  qei_pkg::qei_in_t  in_data,
  output logic              out_valid,
  output qei_pkg::qei_out_t out_data
);
  import qei_pkg::*;

  localparam int XW  = FRAC_BITS + 2;     // 2*ONE - t, and factor f
  localparam int PW1 = XW + 15;           // x * coef
  localparam int SW  = FRAC_BITS + 2;     // s, below 2*ONE
  localparam int DPW = 32 + SW + 1;       // change * s, signed
  localparam int LAT = FRAC_BITS + 5;
  localparam logic [XW-1:0] TWO_ONE = XW'(1) << (FRAC_BITS + 1);

  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Entry: frame masks, special-case select, easing clamp
  // ---------------------------------------------------------------------
  logic                  acc;
  logic [47:0]           e_wide;
  logic [47:0]           d_wide;
  logic [FRAME_BITS-1:0] e_in;
  logic [FRAME_BITS-1:0] d_in;
  logic signed [15:0]    ease_cl;
  logic signed [15:0]    ease_neg;
  qei_side_t             side_in;

  assign acc    = start && !busy;
  assign e_wide = {32'd0, in_data.elapsed_frames};
  assign d_wide = {32'd0, in_data.total_frames};
  assign e_in   = e_wide[FRAME_BITS-1:0];
  assign d_in   = d_wide[FRAME_BITS-1:0];

  always_comb begin
    ease_cl = $signed(in_data.ease_amount);
    if (ease_cl > EASE_MAX) begin
      ease_cl = EASE_MAX;
    end
    if (ease_cl < EASE_MIN) begin
      ease_cl = EASE_MIN;
    end
    ease_neg = -ease_cl;

    side_in.start_value  = in_data.start_value;
    side_in.change_value = in_data.change_value;
    side_in.neg          = ease_cl[15];
    side_in.coef         = ease_cl[15] ? ease_neg[14:0] : ease_cl[14:0];
    if (d_in == '0 || e_in == '0) begin
      side_in.sel = SEL_START;
    end else if (e_in >= d_in) begin
      side_in.sel = SEL_END;
    end else begin
      side_in.sel = SEL_EASE;
    end
  end

  // ---------------------------------------------------------------------
  // t = (e << F) / d
  // ---------------------------------------------------------------------
  logic                 div_vld;
  logic [FRAC_BITS-1:0] div_t;
  qei_side_t            div_side;

  qei_div_pipe #(
    .FRAC_BITS (FRAC_BITS),
    .FRAME_BITS(FRAME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (acc),
    .dividend (e_in),
    .divisor  (d_in),
    .in_side  (side_in),
    .out_valid(div_vld),
    .quotient (div_t),
    .out_side (div_side)
  );

  // ---------------------------------------------------------------------
  // P1: x * coef, x = t (ease-in) or 2*ONE - t (ease-out / linear)
  // ---------------------------------------------------------------------
  logic                 vld_p1_r;
  logic [FRAC_BITS-1:0] t_p1_r;
  qei_side_t            side_p1_r;
  logic [PW1-1:0]       prod1_r;
  logic [XW-1:0]        x_p1;

  assign x_p1 = div_side.neg ? XW'(div_t) : (TWO_ONE - XW'(div_t));

  always_ff @(posedge clk) begin
    t_p1_r    <= div_t;
    side_p1_r <= div_side;
    prod1_r   <= PW1'(x_p1) * PW1'(div_side.coef);
  end

  // ---------------------------------------------------------------------
  // P2: f = (x*coef + (1 - coef)*ONE) >> 14
  // ---------------------------------------------------------------------
  logic                 vld_p2_r;
  logic [FRAC_BITS-1:0] t_p2_r;
  qei_side_t            side_p2_r;
  logic [XW-1:0]        f_r;
  logic [PW1-1:0]       base_p2;
  logic [PW1-1:0]       fw_p2;

  assign base_p2 = PW1'(EASE_ONE - side_p1_r.coef) << FRAC_BITS;
  assign fw_p2   = prod1_r + base_p2;

  always_ff @(posedge clk) begin
    t_p2_r    <= t_p1_r;
    side_p2_r <= side_p1_r;
    f_r       <= fw_p2[EASE_SHIFT +: XW];
  end

  // ---------------------------------------------------------------------
  // P3: s = (t * f) >> F
  // ---------------------------------------------------------------------
  logic                        vld_p3_r;
  qei_side_t                   side_p3_r;
  logic [SW-1:0]               s_r;
  logic [FRAC_BITS+XW-1:0]     sf_p3;

  assign sf_p3 = (FRAC_BITS + XW)'(t_p2_r) * (FRAC_BITS + XW)'(f_r);

  always_ff @(posedge clk) begin
    side_p3_r <= side_p2_r;
    s_r       <= sf_p3[FRAC_BITS +: SW];
  end

  // ---------------------------------------------------------------------
  // P4: change * s, signed
  // ---------------------------------------------------------------------
  logic                  vld_p4_r;
  qei_side_t             side_p4_r;
  logic signed [DPW-1:0] dprod_r;

  always_ff @(posedge clk) begin
    side_p4_r <= side_p3_r;
    dprod_r   <= DPW'($signed(side_p3_r.change_value)) * DPW'($signed({1'b0, s_r}));
  end

  // ---------------------------------------------------------------------
  // P5: delta = floor(change*s / ONE), add start, saturate
  // ---------------------------------------------------------------------
  logic signed [33:0] start34;
  logic signed [33:0] change34;
  logic signed [33:0] delta34;
  logic signed [33:0] sum34;
  qei_out_t           res_nxt;
  logic               out_valid_r;
  qei_out_t           out_data_r;

  always_comb begin
    start34  = {{2{side_p4_r.start_value[31]}}, side_p4_r.start_value};
    change34 = {{2{side_p4_r.change_value[31]}}, side_p4_r.change_value};
    delta34  = dprod_r[FRAC_BITS +: 34];
    case (side_p4_r.sel)
      SEL_START: sum34 = start34;
      SEL_END:   sum34 = start34 + change34;
      SEL_EASE:  sum34 = start34 + delta34;
      default:   sum34 = start34;
    endcase
    if (sum34 > RES_MAX) begin
      res_nxt.result_value = RES_MAX_32;
      res_nxt.saturated    = 1'b1;
    end else if (sum34 < RES_MIN) begin
      res_nxt.result_value = RES_MIN_32;
      res_nxt.saturated    = 1'b1;
    end else begin
      res_nxt.result_value = sum34[31:0];
      res_nxt.saturated    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_nxt;
  end

  // valid bits: the only state reset touches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p1_r    <= 1'b0;
      vld_p2_r    <= 1'b0;
      vld_p3_r    <= 1'b0;
      vld_p4_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_p1_r    <= div_vld;
      vld_p2_r    <= vld_p1_r;
      vld_p3_r    <= vld_p2_r;
      vld_p4_r    <= vld_p3_r;
      out_valid_r <= vld_p4_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every accepted transaction strobes a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("transaction lost in pipeline");

  // the saturation flag only comes with a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.result_value == RES_MAX_32 || out_data.result_value == RES_MIN_32)
    else $error("saturated flag without rail value");

  // start bypass passes the start value through unclamped
  a_start_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    vld_p4_r && side_p4_r.sel == SEL_START |=>
      out_data.result_value == $past(side_p4_r.start_value) && !out_data.saturated)
    else $error("start bypass mismatch");

  // zero easing must give a factor of exactly one
  a_linear_factor: assert property (@(posedge clk) disable iff (!rst_n)
    vld_p1_r && !side_p1_r.neg && side_p1_r.coef == '0 |=>
      f_r == (XW'(1) << FRAC_BITS))
    else $error("linear blend factor is not one");

endmodule
